[rtl/core/time_budget_task_dispatcher_defines.svh]
// Assertion macros for the time budget task dispatcher.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef TIME_BUDGET_TASK_DISPATCHER_DEFINES_SVH
`define TIME_BUDGET_TASK_DISPATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on the rising clock edge, off while reset is high
`define TBTD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on the rising clock edge, reset included
`define TBTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBTD_ASSERT(lbl, clk, rst, prop, msg)
`define TBTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/tbtd_pkg.sv]
// Shared types and codes of the time budget task dispatcher.
// No dependencies; used by the top level and the testbench.
package tbtd_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_LOAD   = 2'd1;
  localparam cmd_t CMD_START  = 2'd2;
  localparam cmd_t CMD_FINISH = 2'd3;

  typedef logic [1:0] event_t;
  localparam event_t EV_ACK      = 2'd0;
  localparam event_t EV_DISPATCH = 2'd1;
  localparam event_t EV_DONE     = 2'd2;

  // run counter halves on reaching this value
  localparam logic [5:0] RUNS_HALVE   = 6'd32;
  localparam logic [5:0] RUNS_RESTART = 6'd16;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  task_index;
    logic [15:0] period_ticks;
    logic [15:0] budget_us;
    logic [15:0] grant_us;
    logic [31:0] elapsed_us;
  } req_t;

  typedef struct packed {
    event_t      event_res;
    logic [3:0]  dispatch_index;
    logic        overrun;
    logic [31:0] spare_total;
    logic [4:0]  run_count;
  } res_t;

  // one task table word
  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] budget;
    logic [15:0] last_run;
  } entry_t;

endpackage

[rtl/core/tbtd_stream_if.sv]
// Valid/ready channel carrying one request or result per handshake.
// Payload type is set per instance; typically a struct from tbtd_pkg.
interface tbtd_stream_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/time_budget_task_dispatcher.sv]
// Top level of the time budget task dispatcher: sequencer, task table and result register.
// Depends on tbtd_pkg, tbtd_stream_if and time_budget_task_dispatcher_defines.svh.
//
//   channel   dir  payload        handshake
//   req       in   tbtd_pkg::req_t valid/ready
//   res       out  tbtd_pkg::res_t valid/ready
//   cfg       in   active_tasks   cfg_we, no wait
//
// Tick, load, an ignored request and a finish that uses up the time go from the accepting
// state straight to emit. A scan examines each entry by a table read, then an eligibility
// compare, and goes to emit when it dispatches or when it runs out of entries.
// Ready stays low for the whole request; a waiting result holds the next one in the
// emit state until the result register frees. Reset is synchronous and clears the whole
// table at once through per-entry valid bits, so no clearing pass follows it.
`include "time_budget_task_dispatcher_defines.svh"

module time_budget_task_dispatcher #(
  parameter int MAX_TASKS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  tbtd_stream_if.sink   req,
  tbtd_stream_if.source res
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] LIM_MAX = CW'(MAX_TASKS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]  state, state_next;
  logic [4:0]  active_tasks;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] budget_left, budget_left_next;
  logic [IW-1:0] cur_task, cur_task_next;
  logic [15:0] cur_interval, cur_interval_next;
  logic [15:0] cur_budget, cur_budget_next;
  logic        run_busy, run_busy_next;
  logic [31:0] spare_sum, spare_sum_next;
  logic [5:0]  spare_runs, spare_runs_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  tbtd_pkg::event_t res_event, res_event_next;
  logic [3:0]  res_idx, res_idx_next;
  logic        res_ovr, res_ovr_next;

  tbtd_pkg::entry_t mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] entry_valid;
  tbtd_pkg::entry_t rd_entry;
  logic        rd_valid;

  logic        wr_en;
  logic [IW-1:0] wr_addr;
  tbtd_pkg::entry_t wr_data;

  logic        out_valid;
  tbtd_pkg::res_t out_data;
  logic        out_load;

  logic [CW-1:0] scan_lim;
  tbtd_pkg::entry_t rd_word;
  logic [15:0] since_run;
  logic        eligible;
  logic        count_en, add_en;
  logic [31:0] sum_add;
  logic [5:0]  runs_inc;

  assign req.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_data;
  assign out_load  = (state == S_EMIT) && (!out_valid || res.ready);

  // entries at or past the register value are never scanned
  assign scan_lim = (32'(active_tasks) < 32'(MAX_TASKS)) ? CW'(active_tasks) : LIM_MAX;

  // an entry never written reads as zero
  assign rd_word   = rd_valid ? rd_entry : '0;
  assign since_run = tick_count - rd_word.last_run;
  assign eligible  = (since_run >= rd_word.interval) && (rd_word.budget <= budget_left);

  assign sum_add  = spare_sum + (add_en ? {16'd0, budget_left} : 32'd0);
  assign runs_inc = spare_runs + 6'd1;

  always_comb begin
    state_next        = state;
    tick_count_next   = tick_count;
    budget_left_next  = budget_left;
    cur_task_next     = cur_task;
    cur_interval_next = cur_interval;
    cur_budget_next   = cur_budget;
    run_busy_next     = run_busy;
    scan_idx_next     = scan_idx;
    res_event_next    = res_event;
    res_idx_next      = res_idx;
    res_ovr_next      = res_ovr;
    count_en          = 1'b0;
    add_en            = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = cur_task;
    wr_data           = '{interval: cur_interval, budget: cur_budget, last_run: tick_count};

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_event_next = tbtd_pkg::EV_ACK;
          res_idx_next   = 4'd0;
          res_ovr_next   = 1'b0;
          state_next     = S_EMIT;
          case (req.data.command)
            tbtd_pkg::CMD_TICK: begin
              tick_count_next = tick_count + 16'd1;
            end
            tbtd_pkg::CMD_LOAD: begin
              if (!run_busy && (32'(req.data.task_index) < 32'(MAX_TASKS))) begin
                wr_en   = 1'b1;
                wr_addr = IW'(req.data.task_index);
                wr_data = '{interval: req.data.period_ticks,
                            budget:   req.data.budget_us,
                            last_run: 16'd0};
              end
            end
            tbtd_pkg::CMD_START: begin
              if (!run_busy) begin
                budget_left_next = req.data.grant_us;
                scan_idx_next    = '0;
                state_next       = S_READ;
              end
            end
            tbtd_pkg::CMD_FINISH: begin
              if (run_busy) begin
                // mark the task as run now; the table word keeps its settings
                wr_en        = 1'b1;
                res_ovr_next = (req.data.elapsed_us > {16'd0, cur_budget});
                if (req.data.elapsed_us >= {16'd0, budget_left}) begin
                  count_en       = 1'b1;
                  run_busy_next  = 1'b0;
                  res_event_next = tbtd_pkg::EV_DONE;
                end else begin
                  budget_left_next = budget_left - req.data.elapsed_us[15:0];
                  scan_idx_next    = CW'(cur_task) + CW'(1);
                  state_next       = S_READ;
                end
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (scan_idx >= scan_lim) begin
          // nothing left to dispatch: bank the unspent time
          add_en         = 1'b1;
          count_en       = 1'b1;
          run_busy_next  = 1'b0;
          res_event_next = tbtd_pkg::EV_DONE;
          state_next     = S_EMIT;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (eligible) begin
          cur_task_next     = scan_idx[IW-1:0];
          cur_interval_next = rd_word.interval;
          cur_budget_next   = rd_word.budget;
          run_busy_next     = 1'b1;
          res_event_next    = tbtd_pkg::EV_DISPATCH;
          res_idx_next      = 4'(scan_idx);
          state_next        = S_EMIT;
        end else begin
          scan_idx_next = scan_idx + CW'(1);
          state_next    = S_READ;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    spare_sum_next  = spare_sum;
    spare_runs_next = spare_runs;
    if (count_en) begin
      if (runs_inc == tbtd_pkg::RUNS_HALVE) begin
        spare_runs_next = tbtd_pkg::RUNS_RESTART;
        spare_sum_next  = sum_add >> 1;
      end else begin
        spare_runs_next = runs_inc;
        spare_sum_next  = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_tasks <= 5'd0;
      tick_count   <= 16'd0;
      budget_left  <= 16'd0;
      cur_task     <= '0;
      cur_interval <= 16'd0;
      cur_budget   <= 16'd0;
      run_busy     <= 1'b0;
      spare_sum    <= 32'd0;
      spare_runs   <= 6'd0;
      scan_idx     <= '0;
      entry_valid  <= '0;
    end else begin
      state        <= state_next;
      tick_count   <= tick_count_next;
      budget_left  <= budget_left_next;
      cur_task     <= cur_task_next;
      cur_interval <= cur_interval_next;
      cur_budget   <= cur_budget_next;
      run_busy     <= run_busy_next;
      spare_sum    <= spare_sum_next;
      spare_runs   <= spare_runs_next;
      scan_idx     <= scan_idx_next;
      if (cfg_we) begin
        active_tasks <= cfg_wdata;
      end
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_event <= res_event_next;
    res_idx   <= res_idx_next;
    res_ovr   <= res_ovr_next;
  end

  // task table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_READ && scan_idx < scan_lim) begin
      rd_entry <= mem[scan_idx[IW-1:0]];
      rd_valid <= entry_valid[scan_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{event_res:      res_event,
                    dispatch_index: res_idx,
                    overrun:        res_ovr,
                    spare_total:    spare_sum,
                    run_count:      spare_runs[4:0]};
    end
  end

  `TBTD_ASSERT(a_check_follows_read, clk, rst,
               state == S_CHECK |-> $past(state) == S_READ, "compare without a table read")
  `TBTD_ASSERT(a_accept_leaves_idle, clk, rst,
               (state == S_IDLE && req.valid) |=> state != S_IDLE, "request accepted but not worked")
  `TBTD_ASSERT(a_dispatch_marks_busy, clk, rst,
               (state == S_EMIT && res_event == tbtd_pkg::EV_DISPATCH) |-> run_busy,
               "dispatch without a run in progress")
  `TBTD_ASSERT_ALWAYS(a_runs_below_halve, clk,
                      rst || (spare_runs < tbtd_pkg::RUNS_HALVE), "run count passed the halving point")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for time_budget_task_dispatcher: directed table, then random phases.
// Needs tbtd_pkg, tbtd_stream_if and the RTL; predicts results from its scheduler copy where a row gives none.
`timescale 1ns / 100ps

module tb_top;

  localparam int N_TASKS        = 16;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 300;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    bit             wr_cfg;
    logic [4:0]     cfg;
    tbtd_pkg::req_t rq;
    bit             typed;
    tbtd_pkg::res_t want;
  } step_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  tbtd_stream_if #(.PAYLOAD_T(tbtd_pkg::req_t)) req_ch ();
  tbtd_stream_if #(.PAYLOAD_T(tbtd_pkg::res_t)) res_ch ();

  time_budget_task_dispatcher #(
    .MAX_TASKS (N_TASKS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler copy
  logic [15:0] m_ticks = '0;
  logic [15:0] m_last_run [N_TASKS] = '{default: '0};
  logic [15:0] m_interval [N_TASKS] = '{default: '0};
  logic [15:0] m_budget [N_TASKS] = '{default: '0};
  logic [15:0] m_time_left = '0;
  logic [3:0]  m_cur_task = '0;
  logic        m_running = 1'b0;
  logic [31:0] m_spare = '0;
  logic [5:0]  m_runs = '0;
  logic [4:0]  m_active = '0;

  tbtd_pkg::res_t due_results [$];
  int   fault_count = 0;
  int   tx_pct = 0;
  int   rx_pct = 0;

  function automatic int scan_end();
    return (m_active < N_TASKS) ? int'(m_active) : N_TASKS;
  endfunction

  function automatic int next_due(int from);
    logic [15:0] since;
    for (int i = from; i < scan_end(); i++) begin
      since = m_ticks - m_last_run[i];
      if (since >= m_interval[i] && m_budget[i] <= m_time_left) return i;
    end
    return scan_end();
  endfunction

  function automatic void bump_runs();
    m_runs = m_runs + 6'd1;
    if (m_runs == tbtd_pkg::RUNS_HALVE) begin
      m_runs  = tbtd_pkg::RUNS_RESTART;
      m_spare = m_spare >> 1;
    end
  endfunction

  function automatic void resume_scan(int from, inout tbtd_pkg::res_t r);
    int i;
    i = next_due(from);
    if (i < scan_end()) begin
      m_cur_task       = i[3:0];
      m_running        = 1'b1;
      r.event_res      = tbtd_pkg::EV_DISPATCH;
      r.dispatch_index = i[3:0];
    end else begin
      m_spare     = m_spare + m_time_left;
      bump_runs();
      m_running   = 1'b0;
      r.event_res = tbtd_pkg::EV_DONE;
    end
  endfunction

  function automatic tbtd_pkg::res_t dispatch_outcome(tbtd_pkg::req_t rq);
    tbtd_pkg::res_t r;
    logic [3:0]     t;
    r = '0;
    case (rq.command)
      tbtd_pkg::CMD_TICK: m_ticks = m_ticks + 16'd1;
      tbtd_pkg::CMD_LOAD: begin
        if (!m_running && rq.task_index < N_TASKS) begin
          m_interval[rq.task_index] = rq.period_ticks;
          m_budget[rq.task_index]   = rq.budget_us;
          m_last_run[rq.task_index] = '0;
        end
      end
      tbtd_pkg::CMD_START: begin
        if (!m_running) begin
          m_time_left = rq.grant_us;
          resume_scan(0, r);
        end
      end
      tbtd_pkg::CMD_FINISH: begin
        if (m_running) begin
          t             = m_cur_task;
          m_last_run[t] = m_ticks;
          r.overrun     = rq.elapsed_us > {16'd0, m_budget[t]};
          if (rq.elapsed_us >= {16'd0, m_time_left}) begin
            // time exhausted: end the run, no spare credit
            bump_runs();
            m_running   = 1'b0;
            r.event_res = tbtd_pkg::EV_DONE;
          end else begin
            m_time_left = m_time_left - rq.elapsed_us[15:0];
            resume_scan(int'(t) + 1, r);
          end
        end
      end
    endcase
    r.spare_total = m_spare;
    r.run_count   = m_runs[4:0];
    return r;
  endfunction

  function automatic bit is_ignored(tbtd_pkg::req_t rq);
    return ((rq.command == tbtd_pkg::CMD_LOAD || rq.command == tbtd_pkg::CMD_START) &&
            m_running) || (rq.command == tbtd_pkg::CMD_FINISH && !m_running);
  endfunction

  function automatic tbtd_pkg::req_t mk_req(tbtd_pkg::cmd_t c, int unsigned idx,
                                            int unsigned ivl, int unsigned mtm,
                                            int unsigned avail, int unsigned taken);
    tbtd_pkg::req_t rq;
    rq.command      = c;
    rq.task_index   = 4'(idx);
    rq.period_ticks = 16'(ivl);
    rq.budget_us    = 16'(mtm);
    rq.grant_us     = 16'(avail);
    rq.elapsed_us   = taken;
    return rq;
  endfunction

  function automatic tbtd_pkg::res_t mk_res(tbtd_pkg::event_t e, int unsigned idx,
                                            int unsigned ovr, int unsigned spare,
                                            int unsigned runs);
    tbtd_pkg::res_t r;
    r.event_res      = e;
    r.dispatch_index = 4'(idx);
    r.overrun        = 1'(ovr);
    r.spare_total    = spare;
    r.run_count      = 5'(runs);
    return r;
  endfunction

  function automatic step_t row(int unsigned w, int unsigned c, tbtd_pkg::req_t q,
                                int unsigned t = 0, tbtd_pkg::res_t e = '0);
    step_t s;
    s.wr_cfg = (w != 0);
    s.cfg    = 5'(c);
    s.rq     = q;
    s.typed  = (t != 0);
    s.want   = e;
    return s;
  endfunction

  // mostly well-formed runs with small intervals and budgets, a few extremes
  function automatic tbtd_pkg::req_t random_request();
    tbtd_pkg::req_t rq;
    int   p;
    rq.command      = tbtd_pkg::cmd_t'($urandom_range(3));
    rq.task_index   = 4'($urandom_range(15));
    rq.period_ticks = 16'($urandom_range(65535));
    rq.budget_us    = 16'($urandom_range(65535));
    rq.grant_us     = 16'($urandom_range(65535));
    rq.elapsed_us   = $urandom;
    p = $urandom_range(99);
    if (m_running) begin
      if (p < 75)      rq.command = tbtd_pkg::CMD_FINISH;
      else if (p < 88) rq.command = tbtd_pkg::CMD_TICK;
      else if (p < 94) rq.command = tbtd_pkg::CMD_LOAD;
      else             rq.command = tbtd_pkg::CMD_START;
    end else begin
      if (p < 35)      rq.command = tbtd_pkg::CMD_TICK;
      else if (p < 55) rq.command = tbtd_pkg::CMD_LOAD;
      else if (p < 92) rq.command = tbtd_pkg::CMD_START;
      else             rq.command = tbtd_pkg::CMD_FINISH;
    end
    case ($urandom_range(9))
      0:       ;
      1, 2:    rq.period_ticks = 16'($urandom_range(300));
      default: rq.period_ticks = 16'($urandom_range(6));
    endcase
    if ($urandom_range(9) != 0) rq.budget_us = 16'($urandom_range(3000));
    case ($urandom_range(9))
      0:       ;
      1:       rq.grant_us = 16'($urandom_range(50));
      default: rq.grant_us = 16'($urandom_range(20000));
    endcase
    case ($urandom_range(9))
      0:       ;
      1:       rq.elapsed_us = $urandom_range(65535);
      2, 3:    rq.elapsed_us = $urandom_range(m_budget[m_cur_task] + 20);
      default: rq.elapsed_us = $urandom_range(m_time_left / 4 + 1);
    endcase
    return rq;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    res_ch.ready <= !rst && !(rx_pct != 0 && $urandom_range(99) < rx_pct);
  end

  always @(posedge clk) begin : check_results
    tbtd_pkg::res_t want;
    tbtd_pkg::res_t got;
    got = res_ch.data;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result with no request pending: %p", $realtime, got);
      end else begin
        want = due_results.pop_front();
        if (got.event_res !== want.event_res || got.dispatch_index !== want.dispatch_index ||
            got.overrun !== want.overrun || got.spare_total !== want.spare_total ||
            got.run_count !== want.run_count) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t: mismatch exp ev=%0d idx=%0d ovr=%0b spare=%0d runs=%0d",
                     $realtime, want.event_res, want.dispatch_index, want.overrun,
                     want.spare_total, want.run_count,
                     " got ev=%0d idx=%0d ovr=%0b spare=%0d runs=%0d",
                     got.event_res, got.dispatch_index, got.overrun,
                     got.spare_total, got.run_count);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < TIMEOUT_CYCLES) begin
      @(posedge clk);
      n++;
    end
    $display("** time_budget_task_dispatcher: FAILED **");
    $finish;
  end

  // hold valid high across back-to-back requests; predict at the accepting edge
  task automatic send_request(tbtd_pkg::req_t rq, bit typed, tbtd_pkg::res_t typed_res);
    tbtd_pkg::res_t p;
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = dispatch_outcome(rq);
    due_results.push_back(typed ? typed_res : p);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_active   = v;
  endtask

  initial begin : stimulus
    step_t          plan [$];
    logic [4:0]     phase_cfg [6];
    tbtd_pkg::req_t rq;
    int             done_items;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;

    // idle at reset, then saturated scan, extremes and out-of-place commands
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1,
                       mk_res(tbtd_pkg::EV_ACK, 0, 0, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_START, 0, 0, 0, 100, 0), 1,
                       mk_res(tbtd_pkg::EV_DONE, 0, 0, 100, 1)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 7), 1,
                       mk_res(tbtd_pkg::EV_ACK, 0, 0, 100, 1)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_LOAD, 3, 3, 50, 0, 0), 1,
                       mk_res(tbtd_pkg::EV_ACK, 0, 0, 100, 1)));
    plan.push_back(row(1, 31, mk_req(tbtd_pkg::CMD_LOAD, 0, 0, 0, 0, 0), 1,
                       mk_res(tbtd_pkg::EV_ACK, 0, 0, 100, 1)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_LOAD, 15, 65535, 65535, 0, 0), 1,
                       mk_res(tbtd_pkg::EV_ACK, 0, 0, 100, 1)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_LOAD, 1, 0, 10, 0, 0), 1,
                       mk_res(tbtd_pkg::EV_ACK, 0, 0, 100, 1)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_START, 0, 0, 0, 65535, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_LOAD, 2, 9, 9, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_START, 0, 0, 0, 65535, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_TICK, 0, 0, 0, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 5)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
                       mk_res(tbtd_pkg::EV_DONE, 0, 1, 100, 2)));
    plan.push_back(row(1, 16, mk_req(tbtd_pkg::CMD_START, 0, 0, 0, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 0)));
    plan.push_back(row(1, 2, mk_req(tbtd_pkg::CMD_START, 0, 0, 0, 5, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 3)));
    plan.push_back(row(1, 4, mk_req(tbtd_pkg::CMD_TICK, 0, 0, 0, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_TICK, 0, 0, 0, 0, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_START, 0, 0, 0, 1000, 0)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 60)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 60)));
    plan.push_back(row(0, 0, mk_req(tbtd_pkg::CMD_FINISH, 0, 0, 0, 0, 60)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].wr_cfg) begin
        settle();
        write_cfg(plan[k].cfg);
      end
      send_request(plan[k].rq, plan[k].typed, plan[k].want);
    end

    phase_cfg = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'($urandom_range(31))};
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_cfg(phase_cfg[ph]);
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 68; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 68; end
        default: begin tx_pct = 8; rx_pct = 8; end
      endcase
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        // hold off mid-phase until every pending result is back
        if (ph == 1 && done_items == PHASE_ITEMS / 2) settle();
        rq = random_request();
        if (!is_ignored(rq)) done_items++;
        send_request(rq, 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0)
      $display("** time_budget_task_dispatcher: PASSED **");
    else
      $display("** time_budget_task_dispatcher: FAILED **");
    $finish;
  end

endmodule
